// ----- design/sipmsc_pkg.sv -----
// ----------------------------------------------------------------------------
// sipmsc_pkg
// Shared types and codes of the SiPM pixel saturation counter: beat payloads,
// operation modes, register indexes and the control groups between modules.
// ----------------------------------------------------------------------------
package sipmsc_pkg;

   // Operation modes carried in the request beat
   localparam logic [1:0] MODE_HIT   = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // Register indexes, byte address is 4 times the index
   localparam logic [2:0] REG_TIME_RESOLVED = 3'd0;
   localparam logic [2:0] REG_TIME_BINS     = 3'd1;
   localparam logic [2:0] REG_RECOVERY_BINS = 3'd2;
   localparam logic [2:0] REG_PIXELS_X      = 3'd3;
   localparam logic [2:0] REG_PIXELS_Y      = 3'd4;

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;
   localparam int SUM_W  = 32;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  pm_index;
      logic [3:0]  time_bin;
      logic [3:0]  pixel_x;
      logic [3:0]  pixel_y;
      logic [15:0] hit_weight;
   } req_payload_type;

   typedef struct packed {
      logic [4:0]       newly_lit;
      logic [SUM_W-1:0] pm_total;
      logic [SUM_W-1:0] bin_total;
   } rsp_payload_type;

   // Register values after range clamping
   typedef struct packed {
      logic       time_resolved;
      logic [4:0] nbins;
      logic [4:0] span_max;
      logic [4:0] ncols;
      logic [4:0] nrows;
   } cfg_type;

   // Read and write strobes toward the state memories
   typedef struct packed {
      logic rd_en;
      logic lit_we;
      logic bin_we;
      logic det_we;
   } store_ctl_type;

endpackage

// ----- design/sipm_pixel_saturation_counter_top.sv -----
// ----------------------------------------------------------------------------
// sipm_pixel_saturation_counter_top
// SiPM microcell saturation counter: lit bitmap and saturating weight sums per
// detector and time bin, kept in on-chip memories.
//
//   channel | direction | handshake           | beat
//   req     | in        | req_valid/req_stall | req_payload_type
//   rsp     | out       | rsp_valid/rsp_stall | rsp_payload_type
//   csr     | in/out    | APB psel/penable    | 32-bit registers at 4*index
//
// A hit or read item passes setup and then the bin loop, which walks span bins
// (1 for untimed hits and reads, up to recovery_bins for timed hits) with one
// lit-map/bin-sum read-modify-write per cycle. An unused-mode item goes
// straight to the result. A new item is accepted only once the previous result
// has moved into the output register. Clear sweeps all NUM_DETECTORS *
// MAX_TIME_BINS * MAX_PIXELS_Y lit words.
// After reset the same sweep zeroes all memories while req_stall stays high;
// register writes are taken throughout.
// The output register holds one result, so one item may be accepted while the
// previous result is stalled on rsp.
// ----------------------------------------------------------------------------
module sipm_pixel_saturation_counter_top
   import sipmsc_pkg::*;
#(
   parameter int NUM_DETECTORS = 16,
   parameter int MAX_TIME_BINS = 16,
   parameter int MAX_PIXELS_X  = 16,
   parameter int MAX_PIXELS_Y  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_payload_type   req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_payload_type   rsp_payload,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int LIT_DEPTH = NUM_DETECTORS * MAX_TIME_BINS * MAX_PIXELS_Y;
   localparam int BIN_DEPTH = NUM_DETECTORS * MAX_TIME_BINS;
   localparam int LIT_AW = (LIT_DEPTH > 1) ? $clog2(LIT_DEPTH) : 1;
   localparam int BIN_AW = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
   localparam int DET_AW = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1;

   cfg_type                 cfg;
   store_ctl_type           ctl;
   logic [LIT_AW-1:0]       lit_rd_addr;
   logic [LIT_AW-1:0]       lit_wr_addr;
   logic [MAX_PIXELS_X-1:0] lit_wr_data;
   logic [MAX_PIXELS_X-1:0] lit_rd_data;
   logic [BIN_AW-1:0]       bin_rd_addr;
   logic [BIN_AW-1:0]       bin_wr_addr;
   logic [SUM_W-1:0]        bin_wr_data;
   logic [SUM_W-1:0]        bin_rd_data;
   logic [DET_AW-1:0]       det_rd_addr;
   logic [DET_AW-1:0]       det_wr_addr;
   logic [SUM_W-1:0]        det_wr_data;
   logic [SUM_W-1:0]        det_rd_data;
   logic                    res_valid;
   logic                    res_take;
   rsp_payload_type         res_data;
   logic                    rsp_valid_ff;
   rsp_payload_type         rsp_payload_ff;

   sipmsc_csr #(
      .MAX_TIME_BINS (MAX_TIME_BINS),
      .MAX_PIXELS_X  (MAX_PIXELS_X),
      .MAX_PIXELS_Y  (MAX_PIXELS_Y)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sipmsc_store #(
      .NUM_DETECTORS (NUM_DETECTORS),
      .MAX_TIME_BINS (MAX_TIME_BINS),
      .MAX_PIXELS_X  (MAX_PIXELS_X),
      .MAX_PIXELS_Y  (MAX_PIXELS_Y)
   ) u_store (
      .clock       (clock),
      .ctl         (ctl),
      .lit_rd_addr (lit_rd_addr),
      .lit_wr_addr (lit_wr_addr),
      .lit_wr_data (lit_wr_data),
      .lit_rd_data (lit_rd_data),
      .bin_rd_addr (bin_rd_addr),
      .bin_wr_addr (bin_wr_addr),
      .bin_wr_data (bin_wr_data),
      .bin_rd_data (bin_rd_data),
      .det_rd_addr (det_rd_addr),
      .det_wr_addr (det_wr_addr),
      .det_wr_data (det_wr_data),
      .det_rd_data (det_rd_data)
   );

   sipmsc_ctrl #(
      .NUM_DETECTORS (NUM_DETECTORS),
      .MAX_TIME_BINS (MAX_TIME_BINS),
      .MAX_PIXELS_X  (MAX_PIXELS_X),
      .MAX_PIXELS_Y  (MAX_PIXELS_Y)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cfg         (cfg),
      .ctl         (ctl),
      .lit_rd_addr (lit_rd_addr),
      .lit_wr_addr (lit_wr_addr),
      .lit_wr_data (lit_wr_data),
      .lit_rd_data (lit_rd_data),
      .bin_rd_addr (bin_rd_addr),
      .bin_wr_addr (bin_wr_addr),
      .bin_wr_data (bin_wr_data),
      .bin_rd_data (bin_rd_data),
      .det_rd_addr (det_rd_addr),
      .det_wr_addr (det_wr_addr),
      .det_wr_data (det_wr_data),
      .det_rd_data (det_rd_data),
      .res_valid   (res_valid),
      .res_take    (res_take),
      .res_data    (res_data)
   );

   // Load the output register when it is empty or its beat leaves
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) rsp_payload_ff <= res_data;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- design/sipmsc_csr.sv -----
// ----------------------------------------------------------------------------
// sipmsc_csr
// Configuration registers behind an APB-style port, with range clamping of
// the geometry and timing values handed to the sequencer.
// ----------------------------------------------------------------------------
module sipmsc_csr
   import sipmsc_pkg::*;
#(
   parameter int MAX_TIME_BINS = 16,
   parameter int MAX_PIXELS_X  = 16,
   parameter int MAX_PIXELS_Y  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   logic       time_resolved_ff;
   logic [4:0] time_bins_ff;
   logic [4:0] recovery_bins_ff;
   logic [4:0] pixels_x_ff;
   logic [4:0] pixels_y_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];

   // Write the addressed register in the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         time_resolved_ff <= 1'b0;
         time_bins_ff     <= 5'd1;
         recovery_bins_ff <= 5'd1;
         pixels_x_ff      <= 5'd16;
         pixels_y_ff      <= 5'd16;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_TIME_RESOLVED: time_resolved_ff <= csr_pwdata[0];
            REG_TIME_BINS:     time_bins_ff     <= csr_pwdata[4:0];
            REG_RECOVERY_BINS: recovery_bins_ff <= csr_pwdata[4:0];
            REG_PIXELS_X:      pixels_x_ff      <= csr_pwdata[4:0];
            REG_PIXELS_Y:      pixels_y_ff      <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   // Return the raw register value
   always_comb begin
      csr_prdata = '0;
      unique case (reg_idx)
         REG_TIME_RESOLVED: csr_prdata = CSR_DW'(time_resolved_ff);
         REG_TIME_BINS:     csr_prdata = CSR_DW'(time_bins_ff);
         REG_RECOVERY_BINS: csr_prdata = CSR_DW'(recovery_bins_ff);
         REG_PIXELS_X:      csr_prdata = CSR_DW'(pixels_x_ff);
         REG_PIXELS_Y:      csr_prdata = CSR_DW'(pixels_y_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // Clamp bins and pixels to 1..max; zero recovery counts as one bin
   always_comb begin
      cfg.time_resolved = time_resolved_ff;
      if (time_bins_ff == 5'd0)
         cfg.nbins = 5'd1;
      else if (32'(time_bins_ff) > MAX_TIME_BINS)
         cfg.nbins = 5'(MAX_TIME_BINS);
      else
         cfg.nbins = time_bins_ff;
      cfg.span_max = (recovery_bins_ff == 5'd0) ? 5'd1 : recovery_bins_ff;
      if (pixels_x_ff == 5'd0)
         cfg.ncols = 5'd1;
      else if (32'(pixels_x_ff) > MAX_PIXELS_X)
         cfg.ncols = 5'(MAX_PIXELS_X);
      else
         cfg.ncols = pixels_x_ff;
      if (pixels_y_ff == 5'd0)
         cfg.nrows = 5'd1;
      else if (32'(pixels_y_ff) > MAX_PIXELS_Y)
         cfg.nrows = 5'(MAX_PIXELS_Y);
      else
         cfg.nrows = pixels_y_ff;
   end

endmodule

// ----- design/sipmsc_store.sv -----
// ----------------------------------------------------------------------------
// sipmsc_store
// State memories: the lit bitmap (one word per detector, bin and row), the
// per-bin sums and the per-detector sums. One write and one registered read
// per memory and cycle.
// ----------------------------------------------------------------------------
module sipmsc_store
   import sipmsc_pkg::*;
#(
   parameter int NUM_DETECTORS = 16,
   parameter int MAX_TIME_BINS = 16,
   parameter int MAX_PIXELS_X  = 16,
   parameter int MAX_PIXELS_Y  = 16,
   localparam int LIT_DEPTH = NUM_DETECTORS * MAX_TIME_BINS * MAX_PIXELS_Y,
   localparam int BIN_DEPTH = NUM_DETECTORS * MAX_TIME_BINS,
   localparam int LIT_AW = (LIT_DEPTH > 1) ? $clog2(LIT_DEPTH) : 1,
   localparam int BIN_AW = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1,
   localparam int DET_AW = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1
) (
   input  logic                    clock,
   input  store_ctl_type           ctl,
   input  logic [LIT_AW-1:0]       lit_rd_addr,
   input  logic [LIT_AW-1:0]       lit_wr_addr,
   input  logic [MAX_PIXELS_X-1:0] lit_wr_data,
   output logic [MAX_PIXELS_X-1:0] lit_rd_data,
   input  logic [BIN_AW-1:0]       bin_rd_addr,
   input  logic [BIN_AW-1:0]       bin_wr_addr,
   input  logic [SUM_W-1:0]        bin_wr_data,
   output logic [SUM_W-1:0]        bin_rd_data,
   input  logic [DET_AW-1:0]       det_rd_addr,
   input  logic [DET_AW-1:0]       det_wr_addr,
   input  logic [SUM_W-1:0]        det_wr_data,
   output logic [SUM_W-1:0]        det_rd_data
);

   logic [MAX_PIXELS_X-1:0] lit_mem [LIT_DEPTH];
   logic [SUM_W-1:0]        bin_mem [BIN_DEPTH];
   logic [SUM_W-1:0]        det_mem [NUM_DETECTORS];
   logic [MAX_PIXELS_X-1:0] lit_q_ff;
   logic [SUM_W-1:0]        bin_q_ff;
   logic [SUM_W-1:0]        det_q_ff;

   // Write ports
   always_ff @(posedge clock) begin
      if (ctl.lit_we) lit_mem[lit_wr_addr] <= lit_wr_data;
      if (ctl.bin_we) bin_mem[bin_wr_addr] <= bin_wr_data;
      if (ctl.det_we) det_mem[det_wr_addr] <= det_wr_data;
   end

   // Read ports, data in the cycle after an enabled read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         lit_q_ff <= lit_mem[lit_rd_addr];
         bin_q_ff <= bin_mem[bin_rd_addr];
         det_q_ff <= det_mem[det_rd_addr];
      end
   end

   assign lit_rd_data = lit_q_ff;
   assign bin_rd_data = bin_q_ff;
   assign det_rd_data = det_q_ff;

endmodule

// ----- design/sipmsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// sipmsc_ctrl
// Sequencer: clearing sweep, item decode, one bin per cycle read-modify-write
// of the lit map and bin sums, running detector sum and result capture.
// ----------------------------------------------------------------------------
module sipmsc_ctrl
   import sipmsc_pkg::*;
#(
   parameter int NUM_DETECTORS = 16,
   parameter int MAX_TIME_BINS = 16,
   parameter int MAX_PIXELS_X  = 16,
   parameter int MAX_PIXELS_Y  = 16,
   localparam int LIT_DEPTH = NUM_DETECTORS * MAX_TIME_BINS * MAX_PIXELS_Y,
   localparam int BIN_DEPTH = NUM_DETECTORS * MAX_TIME_BINS,
   localparam int LIT_AW = (LIT_DEPTH > 1) ? $clog2(LIT_DEPTH) : 1,
   localparam int BIN_AW = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1,
   localparam int DET_AW = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_payload_type         req_payload,
   input  cfg_type                 cfg,
   output store_ctl_type           ctl,
   output logic [LIT_AW-1:0]       lit_rd_addr,
   output logic [LIT_AW-1:0]       lit_wr_addr,
   output logic [MAX_PIXELS_X-1:0] lit_wr_data,
   input  logic [MAX_PIXELS_X-1:0] lit_rd_data,
   output logic [BIN_AW-1:0]       bin_rd_addr,
   output logic [BIN_AW-1:0]       bin_wr_addr,
   output logic [SUM_W-1:0]        bin_wr_data,
   input  logic [SUM_W-1:0]        bin_rd_data,
   output logic [DET_AW-1:0]       det_rd_addr,
   output logic [DET_AW-1:0]       det_wr_addr,
   output logic [SUM_W-1:0]        det_wr_data,
   input  logic [SUM_W-1:0]        det_rd_data,
   output logic                    res_valid,
   input  logic                    res_take,
   output rsp_payload_type         res_data
);

   localparam int LIT_STRIDE = MAX_TIME_BINS * MAX_PIXELS_Y;
   localparam int COL_W = (MAX_PIXELS_X > 1) ? $clog2(MAX_PIXELS_X) : 1;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SETUP = 3'd2;
   localparam logic [2:0] ST_LOOP  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [LIT_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic              clr_cmd_ff, clr_cmd_in;
   logic [3:0]        pm_ff, pm_in;
   logic [15:0]       w_ff, w_in;
   logic [3:0]        t0_ff, t0_in;
   logic [3:0]        col_ff, col_in;
   logic [3:0]        row_ff, row_in;
   logic              wr_allow_ff, wr_allow_in;
   logic              bin_upd_ff, bin_upd_in;
   logic              bin_ok_ff, bin_ok_in;
   logic [4:0]        span_ff, span_in;
   logic [4:0]        k_ff, k_in;
   logic [LIT_AW-1:0] lit_addr_ff, lit_addr_in;
   logic [BIN_AW-1:0] bin_addr_ff, bin_addr_in;
   logic              wb_vld_ff, wb_first_ff, wb_last_ff;
   logic [LIT_AW-1:0] wb_lit_addr_ff;
   logic [BIN_AW-1:0] wb_bin_addr_ff;
   logic [SUM_W-1:0]  run_ff;
   logic [4:0]        res_newly_ff, res_newly_in;
   logic [SUM_W-1:0]  res_pm_ff, res_pm_in;
   logic [SUM_W-1:0]  res_bin_ff, res_bin_in;

   logic              accept;
   logic              pm_ok;
   logic              tb_ok;
   logic              is_hit;
   logic [4:0]        tb_room;
   logic [4:0]        col_cl;
   logic [4:0]        row_cl;
   logic              issue_ok;
   logic              clr_last;
   logic [COL_W-1:0]  col_idx;
   logic [MAX_PIXELS_X-1:0] col_bit;
   logic              fire;
   logic [SUM_W-1:0]  running;
   logic [SUM_W:0]    run_add;
   logic [SUM_W-1:0]  new_run;
   logic [SUM_W:0]    bin_add;
   logic [SUM_W-1:0]  bin_new;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign res_valid = (state_ff == ST_DONE);
   assign issue_ok  = (state_ff == ST_LOOP) && (k_ff < span_ff);
   assign clr_last  = (clr_cnt_ff == LIT_AW'(LIT_DEPTH - 1));

   // Decode the request beat
   assign pm_ok   = 32'(req_payload.pm_index) < NUM_DETECTORS;
   assign tb_ok   = cfg.time_resolved && ({1'b0, req_payload.time_bin} < cfg.nbins);
   assign is_hit  = (req_payload.mode == MODE_HIT);
   assign tb_room = cfg.nbins - {1'b0, req_payload.time_bin};
   assign col_cl  = ({1'b0, req_payload.pixel_x} >= cfg.ncols) ?
                    cfg.ncols - 5'd1 : {1'b0, req_payload.pixel_x};
   assign row_cl  = ({1'b0, req_payload.pixel_y} >= cfg.nrows) ?
                    cfg.nrows - 5'd1 : {1'b0, req_payload.pixel_y};

   // Modify stage: test the pixel, saturate the sums
   assign col_idx = COL_W'(col_ff);
   assign col_bit = MAX_PIXELS_X'(1) << col_idx;
   assign fire    = wr_allow_ff && !lit_rd_data[col_idx];
   assign running = wb_first_ff ? det_rd_data : run_ff;
   assign run_add = {1'b0, running} + (SUM_W + 1)'(w_ff);
   assign new_run = !fire ? running : (run_add[SUM_W] ? '1 : run_add[SUM_W-1:0]);
   assign bin_add = {1'b0, bin_rd_data} + (SUM_W + 1)'(w_ff);
   assign bin_new = !(fire && bin_upd_ff) ? bin_rd_data :
                    (bin_add[SUM_W] ? '1 : bin_add[SUM_W-1:0]);

   // Memory ports: sweep zeros while clearing, else issue and write back
   always_comb begin
      ctl.rd_en   = issue_ok;
      lit_rd_addr = lit_addr_ff;
      bin_rd_addr = bin_addr_ff;
      det_rd_addr = DET_AW'(pm_ff);
      if (state_ff == ST_CLEAR) begin
         ctl.lit_we  = 1'b1;
         ctl.bin_we  = {1'b0, clr_cnt_ff} < (LIT_AW + 1)'(BIN_DEPTH);
         ctl.det_we  = {1'b0, clr_cnt_ff} < (LIT_AW + 1)'(NUM_DETECTORS);
         lit_wr_addr = clr_cnt_ff;
         bin_wr_addr = clr_cnt_ff[BIN_AW-1:0];
         det_wr_addr = clr_cnt_ff[DET_AW-1:0];
         lit_wr_data = '0;
         bin_wr_data = '0;
         det_wr_data = '0;
      end else begin
         ctl.lit_we  = wb_vld_ff && fire;
         ctl.bin_we  = wb_vld_ff && fire && bin_upd_ff;
         ctl.det_we  = wb_vld_ff && wb_last_ff && wr_allow_ff;
         lit_wr_addr = wb_lit_addr_ff;
         bin_wr_addr = wb_bin_addr_ff;
         det_wr_addr = DET_AW'(pm_ff);
         lit_wr_data = lit_rd_data | col_bit;
         bin_wr_data = bin_new;
         det_wr_data = new_run;
      end
   end

   // Next state of the sequencer
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_cmd_in   = clr_cmd_ff;
      pm_in        = pm_ff;
      w_in         = w_ff;
      t0_in        = t0_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      wr_allow_in  = wr_allow_ff;
      bin_upd_in   = bin_upd_ff;
      bin_ok_in    = bin_ok_ff;
      span_in      = span_ff;
      k_in         = k_ff;
      lit_addr_in  = lit_addr_ff;
      bin_addr_in  = bin_addr_ff;
      res_newly_in = res_newly_ff;
      res_pm_in    = res_pm_ff;
      res_bin_in   = res_bin_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + LIT_AW'(1);
            if (clr_last) begin
               state_in = clr_cmd_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               res_newly_in = '0;
               res_pm_in    = '0;
               res_bin_in   = '0;
               pm_in        = req_payload.pm_index;
               w_in         = req_payload.hit_weight;
               t0_in        = tb_ok ? req_payload.time_bin : 4'd0;
               col_in       = col_cl[3:0];
               row_in       = row_cl[3:0];
               wr_allow_in  = is_hit && (!cfg.time_resolved || tb_ok);
               bin_upd_in   = cfg.time_resolved;
               bin_ok_in    = tb_ok;
               span_in      = 5'd1;
               if (is_hit && tb_ok) begin
                  span_in = (cfg.span_max > tb_room) ? tb_room : cfg.span_max;
               end
               priority if (req_payload.mode == MODE_CLEAR) begin
                  state_in   = ST_CLEAR;
                  clr_cmd_in = 1'b1;
                  clr_cnt_in = '0;
               end else if ((is_hit || req_payload.mode == MODE_READ) && pm_ok) begin
                  state_in = ST_SETUP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SETUP: begin
            k_in        = '0;
            bin_addr_in = BIN_AW'(32'(pm_ff) * MAX_TIME_BINS + 32'(t0_ff));
            lit_addr_in = LIT_AW'(32'(pm_ff) * LIT_STRIDE +
                                  32'(t0_ff) * MAX_PIXELS_Y + 32'(row_ff));
            state_in    = ST_LOOP;
         end
         ST_LOOP: begin
            // Advance one bin per cycle
            if (issue_ok) begin
               k_in        = k_ff + 5'd1;
               lit_addr_in = lit_addr_ff + LIT_AW'(MAX_PIXELS_Y);
               bin_addr_in = bin_addr_ff + BIN_AW'(1);
            end
            if (wb_vld_ff) begin
               if (fire) res_newly_in = res_newly_ff + 5'd1;
               if (wb_first_ff) res_bin_in = bin_ok_ff ? bin_new : '0;
               if (wb_last_ff) begin
                  res_pm_in = new_run;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            clr_cmd_in = 1'b0;
            if (res_take) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
         clr_cmd_ff <= 1'b0;
         wb_vld_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         clr_cmd_ff <= clr_cmd_in;
         wb_vld_ff  <= issue_ok;
      end
   end

   // Item fields, addresses and results
   always_ff @(posedge clock) begin
      pm_ff          <= pm_in;
      w_ff           <= w_in;
      t0_ff          <= t0_in;
      col_ff         <= col_in;
      row_ff         <= row_in;
      wr_allow_ff    <= wr_allow_in;
      bin_upd_ff     <= bin_upd_in;
      bin_ok_ff      <= bin_ok_in;
      span_ff        <= span_in;
      k_ff           <= k_in;
      lit_addr_ff    <= lit_addr_in;
      bin_addr_ff    <= bin_addr_in;
      wb_first_ff    <= issue_ok && (k_ff == 5'd0);
      wb_last_ff     <= issue_ok && (k_ff == span_ff - 5'd1);
      wb_lit_addr_ff <= lit_addr_ff;
      wb_bin_addr_ff <= bin_addr_ff;
      res_newly_ff   <= res_newly_in;
      res_pm_ff      <= res_pm_in;
      res_bin_ff     <= res_bin_in;
      if (wb_vld_ff) run_ff <= new_run;
   end

   assign res_data.newly_lit = res_newly_ff;
   assign res_data.pm_total  = res_pm_ff;
   assign res_data.bin_total = res_bin_ff;

   // Write-back only follows an issue of the bin loop
   a_wb_after_issue: assert property (@(posedge clock) disable iff (reset)
      wb_vld_ff |-> $past(state_ff) == ST_LOOP)
      else $error("write-back without a preceding issue");

   // Overlapping issue and write-back never touch the same lit word
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      issue_ok && wb_vld_ff |-> lit_addr_ff != wb_lit_addr_ff)
      else $error("read and write-back hit the same lit word");

   // Bin sums change only in timed mode or during the sweep
   a_bin_timed: assert property (@(posedge clock) disable iff (reset)
      ctl.bin_we && state_ff != ST_CLEAR |-> bin_upd_ff)
      else $error("bin sum written in untimed mode");

   // A hit never lights more bins than its span
   a_newly_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOP && wb_vld_ff && wb_last_ff |=> res_newly_ff <= span_ff)
      else $error("newly lit count exceeds span");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SiPM pixel saturation counter. A behavioral
// copy of the lit bitmap and the saturating sums predicts every result beat.
// Directed tests cover pixel clipping, recovery spans and the clear, read and
// unused modes. Random phases under varied register settings follow, with
// random idling on both channels and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb
   import sipmsc_pkg::*;
();

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int DETECTORS    = 16;
   localparam int BINS         = 16;
   localparam int COLS         = 16;
   localparam int ROWS         = 16;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int DRAIN_TAIL   = 24;
   localparam int HOLD_CYCLES  = 400;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_payload_type   req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_payload_type   rsp_payload;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // Register shadows, raw values as written
   logic       shadow_timed = 1'b0;
   logic [4:0] shadow_bins  = 5'd1;
   logic [4:0] shadow_recov = 5'd1;
   logic [4:0] shadow_cols  = 5'd16;
   logic [4:0] shadow_rows  = 5'd16;

   // Predicted detector state
   logic [15:0] lit_rows [DETECTORS][BINS][ROWS];
   logic [31:0] pm_acc [DETECTORS];
   logic [31:0] bin_acc [BINS][DETECTORS];

   rsp_payload_type pending_counts[$];
   int  mismatch_count = 0;
   bit  calm = 1'b0;
   int  hold_asked = 0;
   int  hold_done = 0;
   int  hold_left = 0;

   sipm_pixel_saturation_counter_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Give up after a generous fixed time
   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic void wipe_counts();
      foreach (lit_rows[d, b, r]) lit_rows[d][b][r] = '0;
      foreach (pm_acc[d]) pm_acc[d] = '0;
      foreach (bin_acc[b, d]) bin_acc[b][d] = '0;
   endfunction

   function automatic logic [31:0] sat_sum(logic [31:0] acc, logic [15:0] weight);
      logic [32:0] s;
      s = {1'b0, acc} + 33'(weight);
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // Apply one beat to the predicted state and return the expected result
   function automatic rsp_payload_type predict_counts(req_payload_type p);
      rsp_payload_type r;
      int nbins, ncols, nrows, span, col, row, bin;
      r = '0;
      nbins = (shadow_bins == 0) ? 1 : ((shadow_bins > BINS) ? BINS : shadow_bins);
      ncols = (shadow_cols == 0) ? 1 : ((shadow_cols > COLS) ? COLS : shadow_cols);
      nrows = (shadow_rows == 0) ? 1 : ((shadow_rows > ROWS) ? ROWS : shadow_rows);
      if (p.mode == MODE_CLEAR) begin
         wipe_counts();
         return r;
      end
      if (p.mode == MODE_UNUSED) return r;
      if (p.mode == MODE_HIT) begin
         // clip the pixel to the last column and row in use
         col = (p.pixel_x >= ncols) ? ncols - 1 : p.pixel_x;
         row = (p.pixel_y >= nrows) ? nrows - 1 : p.pixel_y;
         if (!shadow_timed) begin
            if (!lit_rows[p.pm_index][0][row][col]) begin
               lit_rows[p.pm_index][0][row][col] = 1'b1;
               pm_acc[p.pm_index] = sat_sum(pm_acc[p.pm_index], p.hit_weight);
               r.newly_lit = 5'd1;
            end
         end else if (p.time_bin < nbins) begin
            // light the recovery span, clipped at the last bin
            span = (shadow_recov == 0) ? 1 : shadow_recov;
            if (span > nbins - p.time_bin) span = nbins - p.time_bin;
            for (int i = 0; i < span; i++) begin
               bin = p.time_bin + i;
               if (!lit_rows[p.pm_index][bin][row][col]) begin
                  lit_rows[p.pm_index][bin][row][col] = 1'b1;
                  pm_acc[p.pm_index] = sat_sum(pm_acc[p.pm_index], p.hit_weight);
                  bin_acc[bin][p.pm_index] = sat_sum(bin_acc[bin][p.pm_index], p.hit_weight);
                  r.newly_lit = r.newly_lit + 5'd1;
               end
            end
         end
      end
      r.pm_total = pm_acc[p.pm_index];
      if (shadow_timed && p.time_bin < nbins) r.bin_total = bin_acc[p.time_bin][p.pm_index];
      return r;
   endfunction

   function automatic req_payload_type make_beat(logic [1:0] mode, int pm, int bin, int px,
                                                 int py, int weight);
      req_payload_type p;
      p.mode       = mode;
      p.pm_index   = 4'(pm);
      p.time_bin   = 4'(bin);
      p.pixel_x    = 4'(px);
      p.pixel_y    = 4'(py);
      p.hit_weight = 16'(weight);
      return p;
   endfunction

   // Offer one beat, with an occasional idle gap first
   task automatic send_beat(req_payload_type p);
      if (!calm && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_counts.push_back(predict_counts(p));
   endtask

   // Drop valid, wait for every expected result, then let the pipeline drain
   task automatic settle();
      int waited = 0;
      req_valid <= 1'b0;
      while (pending_counts.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_counts.size() != 0) begin
         $display("%0t outstanding results: expected 0, actual %0d",
                  $time, pending_counts.size());
         mismatch_count++;
         pending_counts.delete();
      end
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   // Register write over the APB port, only once the block is idle
   task automatic set_reg(logic [2:0] idx, logic [31:0] value);
      settle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_TIME_RESOLVED: shadow_timed = value[0];
         REG_TIME_BINS:     shadow_bins  = value[4:0];
         REG_RECOVERY_BINS: shadow_recov = value[4:0];
         REG_PIXELS_X:      shadow_cols  = value[4:0];
         REG_PIXELS_Y:      shadow_rows  = value[4:0];
         default: ;
      endcase
   endtask

   function automatic logic [31:0] pick_setting();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'd16;
         3: return 32'd31;
         default: return $urandom_range(0, 31);
      endcase
   endfunction

   // Result side: random stall, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_done) begin
         hold_done <= hold_asked;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 10);
      end
   end

   // Compare each accepted result beat with the oldest expectation
   always @(posedge clock) begin : check_beats
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_counts.size() == 0) begin
            $display("%0t unexpected result beat: expected none, actual %h", $time, rsp_payload);
            mismatch_count++;
         end else begin
            want = pending_counts.pop_front();
            if (rsp_payload.newly_lit !== want.newly_lit) begin
               $display("%0t newly_lit: expected %0d, actual %0d",
                        $time, want.newly_lit, rsp_payload.newly_lit);
               mismatch_count++;
            end
            if (rsp_payload.pm_total !== want.pm_total) begin
               $display("%0t pm_total: expected %h, actual %h",
                        $time, want.pm_total, rsp_payload.pm_total);
               mismatch_count++;
            end
            if (rsp_payload.bin_total !== want.bin_total) begin
               $display("%0t bin_total: expected %h, actual %h",
                        $time, want.bin_total, rsp_payload.bin_total);
               mismatch_count++;
            end
         end
      end
   end

   // Untimed hits at reset settings: repeats, extremes, read, unused mode, clear
   task automatic test_untimed_hits();
      send_beat(make_beat(MODE_HIT, 0, 0, 0, 0, 16'hFFFF));
      send_beat(make_beat(MODE_HIT, 0, 0, 0, 0, 16'h0001));
      send_beat(make_beat(MODE_HIT, 15, 15, 15, 15, 16'h0000));
      send_beat(make_beat(MODE_HIT, 15, 3, 15, 14, 16'h8000));
      send_beat(make_beat(MODE_READ, 15, 7, 0, 0, 16'h0000));
      send_beat(make_beat(MODE_UNUSED, 0, 15, 15, 15, 16'hFFFF));
      send_beat(make_beat(MODE_CLEAR, 15, 15, 15, 15, 16'hFFFF));
      send_beat(make_beat(MODE_READ, 0, 0, 0, 0, 16'h0000));
   endtask

   // Pixel coordinates past the geometry land on the last column and row
   task automatic test_pixel_geometry();
      set_reg(REG_PIXELS_X, 32'd3);
      set_reg(REG_PIXELS_Y, 32'd0);
      send_beat(make_beat(MODE_HIT, 1, 0, 15, 15, 16'h0100));
      send_beat(make_beat(MODE_HIT, 1, 0, 2, 0, 16'h0005));
      set_reg(REG_PIXELS_X, 32'd31);
      set_reg(REG_PIXELS_Y, 32'd31);
      send_beat(make_beat(MODE_HIT, 1, 0, 15, 15, 16'h0200));
   endtask

   // Timed mode: clipped recovery spans, bins past the limit, range clamps
   task automatic test_timed_recovery();
      set_reg(REG_TIME_RESOLVED, 32'd1);
      set_reg(REG_TIME_BINS, 32'd16);
      set_reg(REG_RECOVERY_BINS, 32'd4);
      send_beat(make_beat(MODE_HIT, 2, 14, 5, 5, 16'h0300));
      send_beat(make_beat(MODE_HIT, 2, 12, 5, 5, 16'h0300));
      send_beat(make_beat(MODE_READ, 2, 15, 0, 0, 16'h0000));
      set_reg(REG_RECOVERY_BINS, 32'd0);
      set_reg(REG_TIME_BINS, 32'd10);
      send_beat(make_beat(MODE_HIT, 2, 12, 6, 6, 16'h0400));
      send_beat(make_beat(MODE_READ, 2, 10, 0, 0, 16'h0000));
      send_beat(make_beat(MODE_HIT, 3, 9, 0, 0, 16'hFFFF));
      set_reg(REG_RECOVERY_BINS, 32'd31);
      set_reg(REG_TIME_BINS, 32'd0);
      send_beat(make_beat(MODE_HIT, 3, 0, 1, 1, 16'h00FF));
      set_reg(REG_TIME_BINS, 32'd31);
      set_reg(REG_RECOVERY_BINS, 32'd16);
      send_beat(make_beat(MODE_HIT, 4, 0, 15, 15, 16'hFFFF));
      send_beat(make_beat(MODE_READ, 4, 15, 0, 0, 16'h0000));
      send_beat(make_beat(MODE_CLEAR, 0, 0, 0, 0, 16'h0000));
   endtask

   // Hold the result side off while beats keep coming, so the input stalls
   task automatic test_output_backpressure();
      calm = 1'b1;
      hold_asked++;
      repeat (30)
         send_beat(make_beat(MODE_HIT, $urandom_range(0, 15), $urandom_range(0, 15),
                             $urandom_range(0, 15), $urandom_range(0, 15),
                             $urandom_range(0, 65535)));
      settle();
      calm = 1'b0;
   endtask

   // Random phases, each under its own register settings
   task automatic test_random_mix();
      req_payload_type p;
      int pm_hi, bin_cap, roll;
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: begin
               set_reg(REG_TIME_RESOLVED, 32'd1);
               set_reg(REG_TIME_BINS, 32'd16);
               set_reg(REG_RECOVERY_BINS, 32'd16);
               set_reg(REG_PIXELS_X, 32'd16);
               set_reg(REG_PIXELS_Y, 32'd16);
            end
            1: begin
               set_reg(REG_TIME_BINS, 32'd1);
               set_reg(REG_RECOVERY_BINS, 32'd1);
               set_reg(REG_PIXELS_X, 32'd1);
               set_reg(REG_PIXELS_Y, 32'd1);
            end
            default: begin
               set_reg(REG_TIME_RESOLVED, $urandom_range(0, 1));
               set_reg(REG_TIME_BINS, pick_setting());
               set_reg(REG_RECOVERY_BINS, pick_setting());
               set_reg(REG_PIXELS_X, pick_setting());
               set_reg(REG_PIXELS_Y, pick_setting());
            end
         endcase
         // one phase runs without any idling
         calm = (phase == 4);
         pm_hi = $urandom_range(0, 1) ? 15 : 3;
         bin_cap = (shadow_bins == 0) ? 0 : ((shadow_bins > BINS) ? BINS - 1 : shadow_bins - 1);
         repeat (190) begin
            roll = $urandom_range(0, 999);
            p.mode = (roll < 5) ? MODE_CLEAR : (roll < 25) ? MODE_UNUSED :
                     (roll < 225) ? MODE_READ : MODE_HIT;
            p.pm_index = 4'($urandom_range(0, pm_hi));
            p.time_bin = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(0, bin_cap));
            p.pixel_x = 4'($urandom_range(0, 15));
            p.pixel_y = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 9) == 0)
               p.hit_weight = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else
               p.hit_weight = 16'($urandom_range(0, 65535));
            send_beat(p);
         end
         calm = 1'b0;
      end
   endtask

   initial begin
      wipe_counts();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_untimed_hits();
      test_pixel_geometry();
      test_timed_recovery();
      test_output_backpressure();
      test_random_mix();
      settle();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
